@@ design/pts_pkg.sv @@
package pts_pkg;

    localparam int SLOTS_DEF      = 64;
    localparam int PRIORITIES_DEF = 4;
    localparam int MAX_WORKERS    = 16;

    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 128;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 5;

    localparam logic [1:0] MODE_DECLARE = 2'd0;
    localparam logic [1:0] MODE_CANCEL  = 2'd1;
    localparam logic [1:0] MODE_RESERVE = 2'd2;
    localparam logic [1:0] MODE_FINISH  = 2'd3;

    localparam logic [2:0] KIND_GRANTED    = 3'd0;
    localparam logic [2:0] KIND_ASSIGNED   = 3'd1;
    localparam logic [2:0] KIND_EMPTY      = 3'd2;
    localparam logic [2:0] KIND_REFUSED    = 3'd3;
    localparam logic [2:0] KIND_ACCEPTED   = 3'd4;
    localparam logic [2:0] KIND_COMPLETION = 3'd5;

    localparam logic [2:0] REF_NONE        = 3'd0;
    localparam logic [2:0] REF_BAD_PRIO    = 3'd1;
    localparam logic [2:0] REF_NO_WORKERS  = 3'd2;
    localparam logic [2:0] REF_STALE       = 3'd3;
    localparam logic [2:0] REF_FULL        = 3'd4;
    localparam logic [2:0] REF_NOT_RUNNING = 3'd5;

    localparam logic [1:0] CONC_DELIVERED  = 2'd0;
    localparam logic [1:0] CONC_REJECTED   = 2'd1;
    localparam logic [1:0] CONC_CANCELLED  = 2'd2;
    localparam logic [1:0] CONC_SUPERSEDED = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_WORKER_COUNT    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESERVED_WORKER = 8'd1;

    typedef struct packed {
        logic [31:0] gen;
        logic [63:0] order;
        logic [2:0]  prio;
        logic [15:0] tag;
    } entry_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [2:0]  refusal;
        logic [5:0]  slot;
        logic [31:0] gen;
        logic [63:0] order;
        logic [1:0]  concl;
        logic [15:0] origin;
        logic        last;
    } res_t;

endpackage

@@ design/priority_task_slot_scheduler.sv @@
// Task-slot scheduler with generation-checked handles. Requests are taken one
// at a time. After decode, a refusal or an empty reserve goes straight to send;
// a fresh declare writes the slot, while a declare from the free stack first
// pops the stack and reads the slot's generation; cancel, reserve and finish
// each read the slot before send. A cancel of a pending task sends a second
// word. A request waits in send while the output is stalled on m_tready. The
// slot, free-stack and link memories have registered reads and are read,
// modified and written back per request, and there is a single output
// register. Pending tasks sit in one doubly linked FIFO per priority, so a
// withdrawal unlinks the slot directly from its neighbours.
module priority_task_slot_scheduler
    import pts_pkg::*;
#(
    parameter int SLOTS      = SLOTS_DEF,
    parameter int PRIORITIES = PRIORITIES_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // priority_req[2:0], origin_tag[18:3], worker_index[22:19], slot_index[28:23],
    // generation[60:29], supersede[61], success[62], zero[63]
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // mode[1:0]
    input  logic [1:0]            s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // refusal[2:0], out_slot[8:3], out_generation[40:9], order_number[104:41],
    // conclusion[106:105], out_origin[122:107], zero[127:123]
    output logic [OUT_DATA_W-1:0] m_tdata,
    // kind[2:0]
    output logic [2:0]            m_tuser,
    output logic                  m_tlast,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int SW = $clog2(SLOTS);
    localparam int PW = (PRIORITIES > 1) ? $clog2(PRIORITIES) : 1;

    typedef enum logic [3:0] {
        ST_IDLE, ST_DECODE, ST_DECL_FREE, ST_DECL_GEN, ST_DECL_WRITE,
        ST_CAN_CHECK, ST_RES_POP, ST_FIN_SEAL, ST_SEND, ST_SEND2
    } state_t;

    state_t state_reg, state_next;

    logic [4:0]  wcount_reg, wcount_next;
    logic [3:0]  resv_reg, resv_next;

    logic [1:0]  mode_reg, mode_next;
    logic [2:0]  prio_reg, prio_next;
    logic [15:0] tag_reg, tag_next;
    logic [3:0]  widx_reg, widx_next;
    logic [5:0]  sidx_reg, sidx_next;
    logic [31:0] genin_reg, genin_next;
    logic        sup_reg, sup_next;
    logic        ok_reg, ok_next;

    logic [SW-1:0] s_reg, s_next;
    logic [31:0]   gen_reg, gen_next;
    logic [PW-1:0] p_reg, p_next;

    logic [SLOTS-1:0] occ_reg, occ_next;
    logic [SLOTS-1:0] run_reg, run_next;
    logic [SLOTS-1:0] cxl_reg, cxl_next;
    logic [SLOTS-1:0] sps_reg, sps_next;

    logic [SW:0]   created_reg, created_next;
    logic [SW:0]   ftop_reg, ftop_next;
    logic [63:0]   order_reg, order_next;

    logic [SW-1:0] head_reg  [PRIORITIES];
    logic [SW-1:0] head_next [PRIORITIES];
    logic [SW-1:0] tail_reg  [PRIORITIES];
    logic [SW-1:0] tail_next [PRIORITIES];
    logic [SW:0]   cnt_reg   [PRIORITIES];
    logic [SW:0]   cnt_next  [PRIORITIES];

    res_t out_reg, out_next;
    logic m_valid_reg, m_valid_next;
    res_t pend_reg, pend_next;
    res_t pend2_reg, pend2_next;
    logic two_reg, two_next;

    // memories
    entry_t        slot_mem [SLOTS];
    logic [SW-1:0] free_mem [SLOTS];
    logic [SW-1:0] next_mem [SLOTS];
    logic [SW-1:0] prev_mem [SLOTS];

    entry_t        slot_rd;
    logic [SW-1:0] free_rd, next_rd, prev_rd;
    logic [SW-1:0] slot_ra, free_ra, link_ra;
    logic          slot_we, free_we, next_we, prev_we;
    logic [SW-1:0] slot_wa, free_wa, next_wa, prev_wa;
    entry_t        slot_wd;
    logic [SW-1:0] free_wd, next_wd, prev_wd;

    logic          out_free;
    logic          only_zero;
    logic          found;
    logic [PW-1:0] psel;
    logic [PW-1:0] pe;
    logic [SW-1:0] sx;
    logic          sidx_ok;
    entry_t        upd;
    logic [1:0]    concl;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tuser   = out_reg.kind;
    assign m_tlast   = out_reg.last;
    assign m_tdata   = {5'b0, out_reg.origin, out_reg.concl, out_reg.order, out_reg.gen,
                        out_reg.slot, out_reg.refusal};

    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_mem[slot_wa] <= slot_wd;
        end
        if (free_we)
        begin
            free_mem[free_wa] <= free_wd;
        end
        if (next_we)
        begin
            next_mem[next_wa] <= next_wd;
        end
        if (prev_we)
        begin
            prev_mem[prev_wa] <= prev_wd;
        end
        slot_rd <= slot_mem[slot_ra];
        free_rd <= free_mem[free_ra];
        next_rd <= next_mem[link_ra];
        prev_rd <= prev_mem[link_ra];
    end

    always_comb
    begin
        state_next   = state_reg;
        wcount_next  = wcount_reg;
        resv_next    = resv_reg;
        mode_next    = mode_reg;
        prio_next    = prio_reg;
        tag_next     = tag_reg;
        widx_next    = widx_reg;
        sidx_next    = sidx_reg;
        genin_next   = genin_reg;
        sup_next     = sup_reg;
        ok_next      = ok_reg;
        s_next       = s_reg;
        gen_next     = gen_reg;
        p_next       = p_reg;
        occ_next     = occ_reg;
        run_next     = run_reg;
        cxl_next     = cxl_reg;
        sps_next     = sps_reg;
        created_next = created_reg;
        ftop_next    = ftop_reg;
        order_next   = order_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        cnt_next     = cnt_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg;
        pend_next    = pend_reg;
        pend2_next   = pend2_reg;
        two_next     = two_reg;

        slot_ra = s_reg;
        free_ra = ftop_reg[SW-1:0];
        link_ra = s_reg;
        slot_we = 1'b0;
        free_we = 1'b0;
        next_we = 1'b0;
        prev_we = 1'b0;
        slot_wa = s_reg;
        free_wa = ftop_reg[SW-1:0];
        next_wa = s_reg;
        prev_wa = s_reg;
        slot_wd = slot_rd;
        free_wd = s_reg;
        next_wd = s_reg;
        prev_wd = s_reg;

        out_free  = !m_valid_reg || m_tready;
        only_zero = (widx_reg == resv_reg) && (wcount_reg > 5'd1) && (MAX_WORKERS > 1);
        sx        = SW'(sidx_reg);
        sidx_ok   = 32'(sidx_reg) < 32'(created_reg);
        pe        = PW'(slot_rd.prio);
        upd       = slot_rd;
        upd.gen   = slot_rd.gen + 32'd1;
        concl     = cxl_reg[s_reg] ? (sps_reg[s_reg] ? CONC_SUPERSEDED : CONC_CANCELLED)
                                   : (ok_reg ? CONC_DELIVERED : CONC_REJECTED);

        found = 1'b0;
        psel  = '0;
        for (int i = 0; i < PRIORITIES; i++)
        begin
            if (!found && cnt_reg[i] != '0 && (!only_zero || i == 0))
            begin
                found = 1'b1;
                psel  = PW'(i);
            end
        end

        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        if (cfg_valid)
        begin
            if (cfg_index == CFG_WORKER_COUNT)
            begin
                wcount_next = cfg_data;
            end
            else if (cfg_index == CFG_RESERVED_WORKER)
            begin
                resv_next = cfg_data[3:0];
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    mode_next  = s_tuser;
                    prio_next  = s_tdata[2:0];
                    tag_next   = s_tdata[18:3];
                    widx_next  = s_tdata[22:19];
                    sidx_next  = s_tdata[28:23];
                    genin_next = s_tdata[60:29];
                    sup_next   = s_tdata[61];
                    ok_next    = s_tdata[62];
                    state_next = ST_DECODE;
                end
            end

            ST_DECODE:
            begin
                pend_next      = '0;
                pend_next.kind = KIND_REFUSED;
                pend_next.last = 1'b1;
                two_next       = 1'b0;
                state_next     = ST_SEND;
                case (mode_reg)
                    MODE_DECLARE:
                    begin
                        if (32'(prio_reg) >= PRIORITIES)
                        begin
                            pend_next.refusal = REF_BAD_PRIO;
                        end
                        else if (wcount_reg == 5'd0)
                        begin
                            pend_next.refusal = REF_NO_WORKERS;
                        end
                        else if (ftop_reg != '0)
                        begin
                            free_ra    = SW'(ftop_reg - 1'b1);
                            ftop_next  = ftop_reg - 1'b1;
                            state_next = ST_DECL_FREE;
                        end
                        else if (32'(created_reg) < SLOTS)
                        begin
                            s_next       = created_reg[SW-1:0];
                            created_next = created_reg + 1'b1;
                            gen_next     = 32'd1;
                            state_next   = ST_DECL_WRITE;
                        end
                        else
                        begin
                            pend_next.refusal = REF_FULL;
                        end
                    end
                    MODE_CANCEL:
                    begin
                        if (genin_reg == 32'd0 || !sidx_ok || !occ_reg[sx])
                        begin
                            pend_next.refusal = REF_STALE;
                        end
                        else
                        begin
                            s_next     = sx;
                            slot_ra    = sx;
                            link_ra    = sx;
                            state_next = ST_CAN_CHECK;
                        end
                    end
                    MODE_RESERVE:
                    begin
                        if (found)
                        begin
                            s_next     = head_reg[psel];
                            p_next     = psel;
                            slot_ra    = head_reg[psel];
                            link_ra    = head_reg[psel];
                            state_next = ST_RES_POP;
                        end
                        else
                        begin
                            pend_next.kind = KIND_EMPTY;
                        end
                    end
                    default:
                    begin
                        if (!sidx_ok || !occ_reg[sx] || !run_reg[sx])
                        begin
                            pend_next.refusal = REF_NOT_RUNNING;
                        end
                        else
                        begin
                            s_next     = sx;
                            slot_ra    = sx;
                            state_next = ST_FIN_SEAL;
                        end
                    end
                endcase
            end

            ST_DECL_FREE:
            begin
                s_next     = free_rd;
                slot_ra    = free_rd;
                state_next = ST_DECL_GEN;
            end

            ST_DECL_GEN:
            begin
                gen_next   = slot_rd.gen;
                state_next = ST_DECL_WRITE;
            end

            ST_DECL_WRITE:
            begin
                order_next    = order_reg + 64'd1;
                slot_we       = 1'b1;
                slot_wd.gen   = gen_reg;
                slot_wd.order = order_reg + 64'd1;
                slot_wd.prio  = prio_reg;
                slot_wd.tag   = tag_reg;
                occ_next[s_reg] = 1'b1;
                run_next[s_reg] = 1'b0;
                cxl_next[s_reg] = 1'b0;
                sps_next[s_reg] = 1'b0;
                // append to the tail of this priority's list
                if (cnt_reg[PW'(prio_reg)] == '0)
                begin
                    head_next[PW'(prio_reg)] = s_reg;
                end
                else
                begin
                    next_we = 1'b1;
                    next_wa = tail_reg[PW'(prio_reg)];
                    next_wd = s_reg;
                    prev_we = 1'b1;
                    prev_wa = s_reg;
                    prev_wd = tail_reg[PW'(prio_reg)];
                end
                tail_next[PW'(prio_reg)] = s_reg;
                cnt_next[PW'(prio_reg)]  = cnt_reg[PW'(prio_reg)] + 1'b1;
                pend_next        = '0;
                pend_next.kind   = KIND_GRANTED;
                pend_next.slot   = 6'(s_reg);
                pend_next.gen    = gen_reg;
                pend_next.order  = order_reg + 64'd1;
                pend_next.origin = tag_reg;
                pend_next.last   = 1'b1;
                two_next         = 1'b0;
                state_next       = ST_SEND;
            end

            ST_CAN_CHECK:
            begin
                state_next = ST_SEND;
                two_next   = 1'b0;
                pend_next  = '0;
                pend_next.last = 1'b1;
                if (slot_rd.gen != genin_reg)
                begin
                    pend_next.kind    = KIND_REFUSED;
                    pend_next.refusal = REF_STALE;
                end
                else
                begin
                    pend_next.kind   = KIND_ACCEPTED;
                    pend_next.slot   = 6'(s_reg);
                    pend_next.gen    = slot_rd.gen;
                    pend_next.order  = slot_rd.order;
                    pend_next.origin = slot_rd.tag;
                    if (run_reg[s_reg])
                    begin
                        cxl_next[s_reg] = 1'b1;
                        sps_next[s_reg] = sup_reg;
                    end
                    else
                    begin
                        pend_next.last = 1'b0;
                        two_next       = 1'b1;
                        // unlink from the pending list
                        if (head_reg[pe] == s_reg)
                        begin
                            head_next[pe] = next_rd;
                        end
                        else
                        begin
                            next_we = 1'b1;
                            next_wa = prev_rd;
                            next_wd = next_rd;
                        end
                        if (tail_reg[pe] == s_reg)
                        begin
                            tail_next[pe] = prev_rd;
                        end
                        else
                        begin
                            prev_we = 1'b1;
                            prev_wa = next_rd;
                            prev_wd = prev_rd;
                        end
                        cnt_next[pe] = cnt_reg[pe] - 1'b1;
                        // seal and free
                        slot_we = 1'b1;
                        slot_wd = upd;
                        occ_next[s_reg] = 1'b0;
                        run_next[s_reg] = 1'b0;
                        cxl_next[s_reg] = 1'b0;
                        sps_next[s_reg] = 1'b0;
                        if (32'(ftop_reg) < SLOTS)
                        begin
                            free_we   = 1'b1;
                            ftop_next = ftop_reg + 1'b1;
                        end
                        pend2_next        = '0;
                        pend2_next.kind   = KIND_COMPLETION;
                        pend2_next.slot   = 6'(s_reg);
                        pend2_next.gen    = slot_rd.gen;
                        pend2_next.order  = slot_rd.order;
                        pend2_next.concl  = sup_reg ? CONC_SUPERSEDED : CONC_CANCELLED;
                        pend2_next.origin = slot_rd.tag;
                        pend2_next.last   = 1'b1;
                    end
                end
            end

            ST_RES_POP:
            begin
                head_next[p_reg] = next_rd;
                cnt_next[p_reg]  = cnt_reg[p_reg] - 1'b1;
                run_next[s_reg]  = 1'b1;
                pend_next        = '0;
                pend_next.kind   = KIND_ASSIGNED;
                pend_next.slot   = 6'(s_reg);
                pend_next.gen    = slot_rd.gen;
                pend_next.order  = slot_rd.order;
                pend_next.origin = slot_rd.tag;
                pend_next.last   = 1'b1;
                two_next         = 1'b0;
                state_next       = ST_SEND;
            end

            ST_FIN_SEAL:
            begin
                slot_we = 1'b1;
                slot_wd = upd;
                occ_next[s_reg] = 1'b0;
                run_next[s_reg] = 1'b0;
                cxl_next[s_reg] = 1'b0;
                sps_next[s_reg] = 1'b0;
                if (32'(ftop_reg) < SLOTS)
                begin
                    free_we   = 1'b1;
                    ftop_next = ftop_reg + 1'b1;
                end
                pend_next        = '0;
                pend_next.kind   = KIND_COMPLETION;
                pend_next.slot   = 6'(s_reg);
                pend_next.gen    = slot_rd.gen;
                pend_next.order  = slot_rd.order;
                pend_next.concl  = concl;
                pend_next.origin = slot_rd.tag;
                pend_next.last   = 1'b1;
                two_next         = 1'b0;
                state_next       = ST_SEND;
            end

            ST_SEND:
            begin
                if (out_free)
                begin
                    out_next     = pend_reg;
                    m_valid_next = 1'b1;
                    state_next   = two_reg ? ST_SEND2 : ST_IDLE;
                end
            end

            ST_SEND2:
            begin
                if (out_free)
                begin
                    out_next     = pend2_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            wcount_reg  <= 5'd2;
            resv_reg    <= 4'd0;
            occ_reg     <= '0;
            run_reg     <= '0;
            cxl_reg     <= '0;
            sps_reg     <= '0;
            created_reg <= '0;
            ftop_reg    <= '0;
            order_reg   <= '0;
            for (int i = 0; i < PRIORITIES; i++)
            begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
                cnt_reg[i]  <= '0;
            end
            m_valid_reg <= 1'b0;
            two_reg     <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            wcount_reg  <= wcount_next;
            resv_reg    <= resv_next;
            occ_reg     <= occ_next;
            run_reg     <= run_next;
            cxl_reg     <= cxl_next;
            sps_reg     <= sps_next;
            created_reg <= created_next;
            ftop_reg    <= ftop_next;
            order_reg   <= order_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
            two_reg     <= two_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg  <= mode_next;
        prio_reg  <= prio_next;
        tag_reg   <= tag_next;
        widx_reg  <= widx_next;
        sidx_reg  <= sidx_next;
        genin_reg <= genin_next;
        sup_reg   <= sup_next;
        ok_reg    <= ok_next;
        s_reg     <= s_next;
        gen_reg   <= gen_next;
        p_reg     <= p_next;
        out_reg   <= out_next;
        pend_reg  <= pend_next;
        pend2_reg <= pend2_next;
    end

endmodule

@@ design/pts_checker.sv @@
module pts_checker
    import pts_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic [2:0]            m_tuser,
    input logic                  m_tlast
);

    // a stalled word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output word changed under stall");

    a_refuse_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == KIND_REFUSED |-> m_tdata[127:3] == '0 && m_tlast)
        else $error("refusal carries payload");

    a_concl: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != KIND_COMPLETION |-> m_tdata[106:105] == 2'd0)
        else $error("conclusion set outside completion");

    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == KIND_EMPTY |-> m_tdata == '0 && m_tlast)
        else $error("nothing-pending word not clean");

endmodule

bind priority_task_slot_scheduler pts_checker u_pts_checker (.*);
